### sv/gnt_pkg.sv
// Package with shared types and constants for the gradient noise turbulence block.
`timescale 1ns / 1ps
package gnt_pkg;
    localparam int TableSize = 256;
    localparam int IdxW = $clog2(TableSize);
    localparam int MaxOctaves = 17;
    localparam int OctW = $clog2(MaxOctaves + 1);

    typedef enum logic [1:0] {
        FUNC_LOAD_PERM = 2'd0,
        FUNC_LOAD_GRAD = 2'd1,
        FUNC_NOISE     = 2'd2,
        FUNC_TURB      = 2'd3
    } t_func;

    // Request to the shared multiplier.
    typedef struct packed {
        logic               go;
        logic signed [33:0] a;
        logic signed [33:0] b;
    } t_mul_req;
endpackage

### sv/gnt_mul.sv
// Shared signed multiplier with a registered product, one request per cycle.
`timescale 1ns / 1ps
module gnt_mul
    import gnt_pkg::*;
(
    input  logic               i_clk,
    input  t_mul_req           i_req,
    output logic signed [67:0] o_prod
);
    logic signed [67:0] r_prod;
    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_prod <= i_req.a * i_req.b;
        end
    end
    assign o_prod = r_prod;
endmodule

### sv/gnt_div.sv
// Restoring divider, one quotient bit per cycle, for the turbulence term.
`timescale 1ns / 1ps
module gnt_div
    import gnt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_num,
    input  logic [23:0] i_den,
    output logic        o_done,
    output logic [47:0] o_quo
);
    logic [47:0] r_quo;
    logic [24:0] r_rem;
    logic [23:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [24:0] n_rem;

    assign n_rem = {r_rem[23:0], r_quo[47]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= 6'd48;
            end else if (r_busy) begin
                if (n_rem >= {1'b0, r_den}) begin
                    r_rem <= n_rem - {1'b0, r_den};
                    r_quo <= {r_quo[46:0], 1'b1};
                end else begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[46:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

### sv/gradient_noise_turbulence.sv
// Top level: 3D gradient noise and octave turbulence with a shared multiplier sequencer.
`timescale 1ns / 1ps
// A table load writes its entry when the request is taken. A noise request
// evaluates eight lattice corners. Each corner has three dependent
// permutation reads and twelve products through the one shared multiplier. A
// turbulence request evaluates the noise and then runs the 48-step serial
// divider for each octave, up to seventeen octaves. Busy is
// high throughout; the result appears for one cycle on o_result_valid and
// cannot be stalled. No clearing pass is needed.
module gradient_noise_turbulence
    import gnt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_func,
    input  logic [7:0]         i_table_index,
    input  logic [7:0]         i_perm_value,
    input  logic signed [15:0] i_grad_x,
    input  logic signed [15:0] i_grad_y,
    input  logic signed [15:0] i_grad_z,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    input  logic [23:0]        i_start_freq,
    output logic               o_result_valid,
    output logic signed [19:0] o_result_value
);
    typedef enum logic [4:0] {
        S_IDLE, S_OCT, S_SCALE, S_SCALE_W, S_CORNER, S_P1, S_P2, S_P3, S_G,
        S_W1, S_W2, S_W3, S_W4, S_WT1, S_WT2, S_D1, S_D2, S_D3, S_TERM,
        S_ACC, S_NDONE, S_DIV, S_DONE
    } t_state;

    logic [7:0]  r_perm [TableSize];
    logic [47:0] r_grad [TableSize];
    logic [7:0]  r_prd;
    logic [47:0] r_grd;
    logic [IdxW-1:0] n_paddr;

    t_state              r_state;
    logic [1:0]          r_func;
    logic signed [31:0]  r_c [3];
    logic [23:0]         r_freq;
    logic [OctW-1:0]     r_oct;
    logic [1:0]          r_ax;
    logic [IdxW-1:0]     r_idx [3];
    logic [15:0]         r_frac [3];
    logic [2:0]          r_corner;
    logic signed [17:0]  r_off [3];
    logic [16:0]         r_fall [3];
    logic [1:0]          r_wax;
    logic [63:0]         r_wtmp;
    logic [16:0]         r_wt;
    logic signed [33:0]  r_dot;
    logic signed [52:0]  r_sum;
    logic [47:0]         r_acc;
    logic signed [19:0]  r_res;
    logic                r_valid;
    logic                r_divgo;

    t_mul_req            n_req;
    logic signed [67:0]  w_prod;
    logic                w_ddone;
    logic [47:0]         w_quo;
    logic signed [52:0]  w_ntr;
    logic [52:0]         w_nabs;
    logic signed [17:0]  w_t;
    logic [17:0]         w_a;

    gnt_mul u_mul (.i_clk(i_clk), .i_req(n_req), .o_prod(w_prod));
    gnt_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_divgo),
        .i_num({w_nabs[39:0], 8'd0}), .i_den(r_freq),
        .o_done(w_ddone), .o_quo(w_quo)
    );

    // Noise truncated toward zero from Q46.
    assign w_ntr  = r_sum[52] ? -((-r_sum) >>> 30) : (r_sum >>> 30);
    assign w_nabs = w_ntr[52] ? 53'(-w_ntr) : 53'(w_ntr);

    assign w_t = r_off[r_wax];
    assign w_a = w_t[17] ? 18'(-w_t) : 18'(w_t);

    always_comb begin
        n_req.go = 1'b1;
        n_req.a  = '0;
        n_req.b  = '0;
        unique case (r_state)
            S_SCALE: begin
                n_req.a = 34'(r_c[r_ax]);
                n_req.b = (r_func == FUNC_NOISE) ? 34'sd256 : 34'($signed({1'b0, r_freq}));
            end
            S_W1: begin
                n_req.a = 34'($signed({1'b0, w_a}));
                n_req.b = 34'($signed({1'b0, w_a}));
            end
            S_W2: begin
                n_req.a = 34'($signed({1'b0, w_prod[32:0]}));
                n_req.b = 34'($signed({1'b0, w_a}));
            end
            S_WT1: begin
                n_req.a = 34'($signed({1'b0, r_fall[0]}));
                n_req.b = 34'($signed({1'b0, r_fall[1]}));
            end
            S_WT2: begin
                n_req.a = 34'($signed({1'b0, w_prod[32:16]}));
                n_req.b = 34'($signed({1'b0, r_fall[2]}));
            end
            S_D1: begin
                n_req.a = 34'($signed(r_grd[15:0]));
                n_req.b = 34'(r_off[0]);
            end
            S_D2: begin
                n_req.a = 34'($signed(r_grd[31:16]));
                n_req.b = 34'(r_off[1]);
            end
            S_D3: begin
                n_req.a = 34'($signed(r_grd[47:32]));
                n_req.b = 34'(r_off[2]);
            end
            S_TERM: begin
                n_req.a = 34'($signed({1'b0, r_wt}));
                n_req.b = r_dot + 34'(w_prod);
            end
            default: n_req.go = 1'b0;
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_P1:    n_paddr = r_idx[2] + IdxW'(r_corner[0]);
            S_P2:    n_paddr = r_idx[1] + IdxW'(r_corner[1]) + r_prd;
            S_P3:    n_paddr = r_idx[0] + IdxW'(r_corner[2]) + r_prd;
            default: n_paddr = i_table_index;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy && i_func == FUNC_LOAD_PERM) begin
            r_perm[i_table_index] <= i_perm_value;
        end
        if (start && !busy && i_func == FUNC_LOAD_GRAD) begin
            r_grad[i_table_index] <= {i_grad_z, i_grad_y, i_grad_x};
        end
        r_prd <= r_perm[n_paddr];
        if (r_state == S_G) begin
            r_grd <= r_grad[r_prd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_divgo <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_divgo <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_func <= i_func;
                        r_c[0] <= i_coord_x;
                        r_c[1] <= i_coord_y;
                        r_c[2] <= i_coord_z;
                        r_freq <= i_start_freq;
                        r_oct  <= '0;
                        r_acc  <= '0;
                        r_res  <= '0;
                        if (i_func == FUNC_NOISE || i_func == FUNC_TURB) begin
                            r_state <= S_OCT;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_OCT: begin
                    r_ax  <= 2'd0;
                    r_sum <= '0;
                    if (r_func == FUNC_TURB &&
                        (r_freq < 24'd256 || r_oct == OctW'(MaxOctaves))) begin
                        r_res   <= (r_acc > 48'd524287) ? 20'sd524287 : 20'(r_acc);
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: r_state <= S_SCALE_W;
                S_SCALE_W: begin
                    r_idx[r_ax]  <= w_prod[24+IdxW-1:24];
                    r_frac[r_ax] <= w_prod[23:8];
                    if (r_ax == 2'd2) begin
                        r_corner <= 3'd0;
                        r_state  <= S_CORNER;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_SCALE;
                    end
                end
                S_CORNER: begin
                    for (int k = 0; k < 3; k++) begin
                        r_off[k] <= $signed({2'b00, r_frac[k]}) -
                                    (r_corner[2-k] ? 18'sd65536 : 18'sd0);
                    end
                    r_state <= S_P1;
                end
                S_P1: r_state <= S_P2;
                S_P2: r_state <= S_P3;
                S_P3: r_state <= S_G;
                S_G: begin
                    r_wax   <= 2'd0;
                    r_state <= S_W1;
                end
                S_W1: r_state <= S_W2;
                S_W2: begin
                    r_wtmp  <= 64'(w_prod);
                    r_state <= S_W3;
                end
                S_W3: r_state <= S_W4;
                S_W4: begin
                    // 2a^3 - 3a^2*2^16 + 2^48, then Q1.16.
                    r_fall[r_wax] <= (w_a > 18'd65536) ? 17'd0 :
                        17'((2 * w_prod[63:0] - 3 * (r_wtmp << 16) + (64'd1 << 48)) >> 32);
                    if (r_wax == 2'd2) begin
                        r_state <= S_WT1;
                    end else begin
                        r_wax   <= r_wax + 2'd1;
                        r_state <= S_W1;
                    end
                end
                S_WT1: r_state <= S_WT2;
                S_WT2: r_state <= S_D1;
                S_D1: begin
                    r_wt    <= w_prod[32:16];
                    r_state <= S_D2;
                end
                S_D2: begin
                    r_dot   <= 34'(w_prod);
                    r_state <= S_D3;
                end
                S_D3: begin
                    r_dot   <= r_dot + 34'(w_prod);
                    r_state <= S_TERM;
                end
                S_TERM: begin
                    r_dot   <= r_dot + 34'(w_prod);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sum <= r_sum + 53'(w_prod);
                    if (r_corner == 3'd7) begin
                        r_state <= S_NDONE;
                    end else begin
                        r_corner <= r_corner + 3'd1;
                        r_state  <= S_CORNER;
                    end
                end
                S_NDONE: begin
                    if (r_func == FUNC_NOISE) begin
                        r_res <= (w_ntr > 53'sd524287) ? 20'sd524287 :
                                 (w_ntr < -53'sd524288) ? -20'sd524288 : 20'(w_ntr);
                        r_state <= S_DONE;
                    end else begin
                        r_divgo <= 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_ddone) begin
                        r_acc   <= r_acc + w_quo;
                        r_freq  <= r_freq >> 1;
                        r_oct   <= r_oct + OctW'(1);
                        r_state <= S_OCT;
                    end
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_valid;
    assign o_result_value = r_res;

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid) else $error("double result");
    a_busy_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("not busy after request");
    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ddone |-> r_state == S_DIV) else $error("divider done outside wait");
endmodule
